FILE: design/lge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_pkg
// Shared widths, defaults and Life rule constants for the generation engine.
// ----------------------------------------------------------------------------
package lge_pkg;

  localparam int GRID_DIM_DEF = 32;
  localparam int CELLS_W      = 32;
  localparam int ROW_IDX_W    = 6;
  localparam int GEN_W        = 8;
  localparam int COUNT_W      = 4;

  localparam logic [GEN_W-1:0]   GEN_RESET   = 8'd1;
  localparam logic [COUNT_W-1:0] SURVIVE_CNT = 4'd2;
  localparam logic [COUNT_W-1:0] BIRTH_CNT   = 4'd3;

endpackage

FILE: design/lge_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_if
// Request channels of the generation engine: row load in, evolved rows out.
// ----------------------------------------------------------------------------
interface lge_in_if;
  logic                        valid;
  logic                        ready;
  logic [lge_pkg::CELLS_W-1:0] row_cells;
  logic                        row_is_last;

  modport source (output valid, output row_cells, output row_is_last, input ready);
  modport sink   (input valid, input row_cells, input row_is_last, output ready);
endinterface

interface lge_out_if;
  logic                          valid;
  logic                          ready;
  logic [lge_pkg::CELLS_W-1:0]   result_cells;
  logic [lge_pkg::ROW_IDX_W-1:0] result_row;
  logic                          result_last;

  modport source (output valid, output result_cells, output result_row,
                  output result_last, input ready);
  modport sink   (input valid, input result_cells, input result_row,
                  input result_last, output ready);
endinterface

FILE: design/life_generation_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_engine
// Toroidal Conway Life engine: load a grid by rows, evolve, emit all rows.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one grid row per request; rows land at a wrapping load
//   counter, one per cycle. A request with row_is_last set closes the load.
//   The engine then runs cfg_wdata generations (written through cfg_we while
//   idle, reset value 1), one row per cycle, all column lanes evolving a row
//   at once while the grid rotates past them. It then emits GRID_DIM
//   requests on out_rsp, one per cycle when the receiver is ready, with the
//   row index and result_last on the final row. in_req.ready is low from the
//   last row until the final row has entered the output register; the next
//   load may begin while that row still waits. A stalled receiver holds the
//   output register and halts emission. Reset clears the grid to all dead,
//   the load counter to zero and the generation count to 1.
// ----------------------------------------------------------------------------
module life_generation_engine #(
  parameter int GRID_DIM = lge_pkg::GRID_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lge_in_if.sink                    in_req,
  lge_out_if.source                 out_rsp,
  input  logic                      cfg_we,
  input  logic [lge_pkg::GEN_W-1:0] cfg_wdata
);

  localparam int CW = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam logic [CW-1:0] LAST_ROW = CW'(GRID_DIM - 1);

  typedef enum logic [1:0] {S_LOAD, S_GEN, S_EMIT} state_t;

  state_t                    state_r;
  logic [GRID_DIM-1:0]       grid_r [GRID_DIM];
  logic [CW-1:0]             load_cnt_r;
  logic [CW-1:0]             row_cnt_r;
  logic [lge_pkg::GEN_W-1:0] gens_cfg_r;
  logic [lge_pkg::GEN_W-1:0] gen_left_r;
  logic [GRID_DIM-1:0]       first_r;
  logic [GRID_DIM-1:0]       prev_r;
  logic                      out_valid_r;
  logic [lge_pkg::CELLS_W-1:0]   out_cells_r;
  logic [lge_pkg::ROW_IDX_W-1:0] out_row_r;
  logic                      out_last_r;

  logic [GRID_DIM-1:0] above_row;
  logic [GRID_DIM-1:0] below_row;
  logic [GRID_DIM-1:0] new_row;
  logic                in_fire;
  logic                out_load;

  assign above_row = (row_cnt_r == '0) ? grid_r[GRID_DIM-1] : prev_r;
  assign below_row = (row_cnt_r == LAST_ROW) ? first_r : grid_r[1];

  lge_row_evolve #(.GRID_DIM(GRID_DIM)) u_evolve (
    .above    (above_row),
    .here     (grid_r[0]),
    .below    (below_row),
    .next_row (new_row)
  );

  assign in_req.ready = (state_r == S_LOAD);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_load     = (state_r == S_EMIT) && (!out_valid_r || out_rsp.ready);

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.result_cells = out_cells_r;
  assign out_rsp.result_row   = out_row_r;
  assign out_rsp.result_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      row_cnt_r   <= '0;
      gens_cfg_r  <= lge_pkg::GEN_RESET;
      gen_left_r  <= '0;
      first_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < GRID_DIM; i++) grid_r[i] <= '0;
    end else begin
      if (cfg_we) gens_cfg_r <= cfg_wdata;
      if (out_valid_r && out_rsp.ready && !out_load) out_valid_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            grid_r[load_cnt_r] <= GRID_DIM'(in_req.row_cells);
            load_cnt_r <= (in_req.row_is_last || (load_cnt_r == LAST_ROW)) ?
                          '0 : load_cnt_r + 1'b1;
            if (in_req.row_is_last) begin
              row_cnt_r  <= '0;
              gen_left_r <= gens_cfg_r;
              state_r    <= (gens_cfg_r == '0) ? S_EMIT : S_GEN;
            end
          end
        end
        S_GEN: begin
          if (row_cnt_r == '0) first_r <= grid_r[0];
          prev_r <= grid_r[0];
          for (int i = 0; i < GRID_DIM - 1; i++) grid_r[i] <= grid_r[i+1];
          grid_r[GRID_DIM-1] <= new_row;
          if (row_cnt_r == LAST_ROW) begin
            row_cnt_r  <= '0;
            gen_left_r <= gen_left_r - 1'b1;
            if (gen_left_r == lge_pkg::GEN_W'(1)) state_r <= S_EMIT;
          end else begin
            row_cnt_r <= row_cnt_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_cells_r <= lge_pkg::CELLS_W'(grid_r[0]);
            out_row_r   <= lge_pkg::ROW_IDX_W'(row_cnt_r);
            out_last_r  <= (row_cnt_r == LAST_ROW);
            for (int i = 0; i < GRID_DIM - 1; i++) grid_r[i] <= grid_r[i+1];
            grid_r[GRID_DIM-1] <= grid_r[0];
            if (row_cnt_r == LAST_ROW) begin
              row_cnt_r <= '0;
              state_r   <= S_LOAD;
            end else begin
              row_cnt_r <= row_cnt_r + 1'b1;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  a_last_closes_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_req.row_is_last |=> !in_req.ready)
    else $error("load not closed after last row");

  a_last_row_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_row_r == lge_pkg::ROW_IDX_W'(GRID_DIM - 1))
    else $error("last flag on wrong row");

  a_counter_rewound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> load_cnt_r == '0)
    else $error("load counter not rewound during run");

endmodule

FILE: design/lge_cell_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_cell_lane
// One column lane: counts the eight neighbors and applies the Life rule.
// ----------------------------------------------------------------------------
module lge_cell_lane (
  input  logic [2:0] above,
  input  logic [2:0] here,
  input  logic [2:0] below,
  output logic       alive
);

  logic [lge_pkg::COUNT_W-1:0] cnt;

  assign cnt = lge_pkg::COUNT_W'(above[0]) + lge_pkg::COUNT_W'(above[1])
             + lge_pkg::COUNT_W'(above[2]) + lge_pkg::COUNT_W'(here[0])
             + lge_pkg::COUNT_W'(here[2])  + lge_pkg::COUNT_W'(below[0])
             + lge_pkg::COUNT_W'(below[1]) + lge_pkg::COUNT_W'(below[2]);

  assign alive = (cnt == lge_pkg::BIRTH_CNT) || (here[1] && (cnt == lge_pkg::SURVIVE_CNT));

endmodule

FILE: design/lge_row_evolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_row_evolve
// One lane per column on a torus; merges the lane results into the new row.
// ----------------------------------------------------------------------------
module lge_row_evolve #(
  parameter int GRID_DIM = lge_pkg::GRID_DIM_DEF
) (
  input  logic [GRID_DIM-1:0] above,
  input  logic [GRID_DIM-1:0] here,
  input  logic [GRID_DIM-1:0] below,
  output logic [GRID_DIM-1:0] next_row
);

  logic [GRID_DIM-1:0] lane_alive;

  for (genvar j = 0; j < GRID_DIM; j++) begin : g_lane
    localparam int L = (j + GRID_DIM - 1) % GRID_DIM;
    localparam int R = (j + 1) % GRID_DIM;
    lge_cell_lane u_lane (
      .above ({above[R], above[j], above[L]}),
      .here  ({here[R],  here[j],  here[L]}),
      .below ({below[R], below[j], below[L]}),
      .alive (lane_alive[j])
    );
  end

  assign next_row = lane_alive;

endmodule
